// ===== design/imurfc_pkg.sv =====
// types and constants shared by the imu response frame checker
// no dependencies; imported by every module of the block
`default_nettype none

package imurfc_pkg;

  // frame layout
  localparam int unsigned FrameBytes = 23;
  localparam int unsigned DataWords  = 10;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned SlotW      = 4;

  // byte index of the last data byte and of the checksum low byte
  localparam logic [IdxW-1:0] LastDataIdx = IdxW'(2 * DataWords);
  localparam logic [IdxW-1:0] CheckLoIdx  = IdxW'(FrameBytes - 1);
  localparam logic [IdxW-1:0] FirstIdx    = IdxW'(1);

  // reset value of the command byte register
  localparam logic [7:0] CmdReset = 8'h31;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_HEADER   = 2'd1,
    STATUS_BAD_CHECKSUM = 2'd2,
    STATUS_SHORT        = 2'd3
  } frame_status_e;

  // one received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_first;
  } in_item_t;

  // one frame result
  typedef struct packed {
    logic signed [15:0] roll_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] yaw_raw;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    logic signed [15:0] rate_x_raw;
    logic signed [15:0] rate_y_raw;
    logic signed [15:0] rate_z_raw;
    logic        [15:0] timer_word;
    logic        [1:0]  frame_status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/imu_response_frame_checker_core.sv =====
// top level of the imu response frame checker: input register, frame
// tracker, result register and command byte register; depends on imurfc_pkg
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  cfg     | in        | cfg_we_i                | cfg_wdata_i (command byte)
//  in      | in        | in_valid_i / in_ready_o | in_item_i (one byte)
//  out     | out       | out_valid_o/out_ready_i | out_item_o (frame result)
//
// one byte item per cycle sustained while no result waits untaken; a result is valid once the
// closing byte (or the early header) is accepted and has passed through the input
// register, and the tracker logic has loaded the result register.
// reset clears the frame state and the valid flags, command byte to 0x31.
// a byte that ends a frame waits in the input register only while the
// result register holds an untaken result; the input is held off meanwhile,
// and no other byte ever waits there.
`default_nettype none

module imu_response_frame_checker_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [7:0]            cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire imurfc_pkg::in_item_t  in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output imurfc_pkg::out_item_t      out_item_o
);
  import imurfc_pkg::*;

  logic [7:0] cmd_q;
  logic       s1_valid_q;
  in_item_t   s1_item_q;
  logic       out_valid_q;
  out_item_t  out_item_q;

  logic       emit;
  out_item_t  result;
  logic       out_free, s1_adv;

  // command byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CmdReset;
    end else if (cfg_we_i) begin
      cmd_q <= cfg_wdata_i;
    end
  end

  // the held byte moves on unless it makes a result with no room for it
  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    s1_adv     = s1_valid_q && (!emit || out_free);
    in_ready_o = !s1_valid_q || s1_adv;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  // frame tracker
  imurfc_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_item_q),
    .cmd_i    (cmd_q),
    .emit_o   (emit),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a byte waits only behind an untaken result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> (emit && out_valid_q && !out_ready_i))
    else $error("input register stalled without a blocked result");

  // a new result never overwrites one that is not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_item_q))
    else $error("pending result overwritten");

  // a result follows each step that emits
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && emit) |=> out_valid_q)
    else $error("emitted result lost");

endmodule

`default_nettype wire

// ===== design/imurfc_frame.sv =====
// frame tracking state, word capture, checksum and status decision
// depends on imurfc_pkg
`default_nettype none

module imurfc_frame (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire imurfc_pkg::in_item_t item_i,
  input  wire logic [7:0]         cmd_i,
  output logic                    emit_o,
  output imurfc_pkg::out_item_t   result_o
);
  import imurfc_pkg::*;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic             open_q, open_d;
  logic             hdr_q, hdr_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       hold_q, hold_d;
  logic [15:0]      store_q [DataWords];

  logic [15:0]      word;
  logic             is_first, is_odd, is_data, is_check, short_hit;
  logic             store_clr, store_wr;
  logic [SlotW-1:0] slot;
  frame_status_e    status;

  // classify the byte against the open frame
  always_comb begin
    word      = {hold_q, item_i.rx_byte};
    is_first  = item_i.frame_first;
    is_odd    = idx_q[0];
    is_data   = open_q && !is_first && !is_odd && (idx_q <= LastDataIdx);
    is_check  = open_q && !is_first && !is_odd && (idx_q > LastDataIdx);
    short_hit = open_q && is_first;
    slot      = idx_q[IdxW-1:1] - SlotW'(1);
    emit_o    = short_hit || is_check;
  end

  // status priority: short frame, then bad header, then bad checksum
  always_comb begin
    if (short_hit) begin
      status = STATUS_SHORT;
    end else if (!hdr_q) begin
      status = STATUS_BAD_HEADER;
    end else if (word != sum_q) begin
      status = STATUS_BAD_CHECKSUM;
    end else begin
      status = STATUS_OK;
    end
  end

  // result is the store as it stands before this byte
  always_comb begin
    result_o.roll_raw     = store_q[0];
    result_o.pitch_raw    = store_q[1];
    result_o.yaw_raw      = store_q[2];
    result_o.accel_x_raw  = store_q[3];
    result_o.accel_y_raw  = store_q[4];
    result_o.accel_z_raw  = store_q[5];
    result_o.rate_x_raw   = store_q[6];
    result_o.rate_y_raw   = store_q[7];
    result_o.rate_z_raw   = store_q[8];
    result_o.timer_word   = store_q[9];
    result_o.frame_status = status;
  end

  // next state of the frame tracker
  always_comb begin
    idx_d     = idx_q;
    open_d    = open_q;
    hdr_d     = hdr_q;
    sum_d     = sum_q;
    hold_d    = hold_q;
    store_clr = 1'b0;
    store_wr  = 1'b0;
    if (step_i) begin
      if (is_first) begin
        open_d    = 1'b1;
        hdr_d     = (item_i.rx_byte == cmd_i);
        sum_d     = {8'h00, cmd_i};
        hold_d    = 8'h00;
        idx_d     = FirstIdx;
        store_clr = 1'b1;
      end else if (open_q) begin
        if (is_odd) begin
          hold_d = item_i.rx_byte;
          idx_d  = idx_q + IdxW'(1);
        end else if (is_data) begin
          sum_d    = sum_q + word;
          idx_d    = idx_q + IdxW'(1);
          store_wr = 1'b1;
        end else begin
          open_d = 1'b0;
          idx_d  = '0;
        end
      end
    end
  end

  // tracker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      open_q <= 1'b0;
      hdr_q  <= 1'b0;
      sum_q  <= '0;
      hold_q <= '0;
    end else begin
      idx_q  <= idx_d;
      open_q <= open_d;
      hdr_q  <= hdr_d;
      sum_q  <= sum_d;
      hold_q <= hold_d;
    end
  end

  // word store, cleared at each header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DataWords; k++) begin
        store_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < DataWords; k++) begin
        if (store_clr) begin
          store_q[k] <= '0;
        end else if (store_wr && (slot == SlotW'(k))) begin
          store_q[k] <= word;
        end
      end
    end
  end

  // an open frame always sits between header and checksum low byte
  a_open_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (idx_q != '0) && (idx_q <= CheckLoIdx))
    else $error("frame index out of range while open");

  a_closed_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (idx_q == '0))
    else $error("frame index not cleared while closed");

  a_header_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.frame_first) |=> (open_q && (idx_q == FirstIdx)))
    else $error("header byte did not open a frame");

  a_check_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && is_check) |-> (idx_q == CheckLoIdx))
    else $error("checksum taken at wrong byte");

endmodule

`default_nettype wire

// ===== test/tb_imu_response_frame_checker_core.sv =====
// testbench for imu_response_frame_checker_core: random and directed response frames,
// a cycle-level frame tracker that predicts every result, and field-by-field checks
// depends on imurfc_pkg and the core; needs nothing else
`default_nettype none

module tb_imu_response_frame_checker_core;
  import imurfc_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PhaseBytes  = 225;
  localparam int unsigned SettleTicks = 8;

  // clock, reset and block ports
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;

  // stimulus and expectation stores
  in_item_t    pending_bytes[$];
  in_item_t    carried_bytes[$];
  out_item_t   expected_frames[$];
  int unsigned queued_bytes = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // frame tracker state (mirrors the block)
  logic [7:0]      cmd_cfg = CmdReset;
  logic [IdxW-1:0] pos = '0;
  logic            fr_open = 1'b0;
  logic            hdr_ok = 1'b0;
  logic [15:0]     csum = '0;
  logic [7:0]      hi_hold = '0;
  logic [15:0]     frame_words [DataWords] = '{default: 16'h0000};

  // sender and receiver pacing
  bit              byte_taken = 1'b0;
  int unsigned     burst_left = 0;
  int unsigned     gap_left = 0;
  bit              hold_go = 1'b0;
  int unsigned     hold_cnt = 0;
  logic [15:0]     rdy_pat = 16'hFFFF;
  int unsigned     pat_age = 0;

  imu_response_frame_checker_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result for the currently tracked frame
  function automatic out_item_t frame_result(frame_status_e st);
    out_item_t r;
    r.roll_raw     = frame_words[0];
    r.pitch_raw    = frame_words[1];
    r.yaw_raw      = frame_words[2];
    r.accel_x_raw  = frame_words[3];
    r.accel_y_raw  = frame_words[4];
    r.accel_z_raw  = frame_words[5];
    r.rate_x_raw   = frame_words[6];
    r.rate_y_raw   = frame_words[7];
    r.rate_z_raw   = frame_words[8];
    r.timer_word   = frame_words[9];
    r.frame_status = st;
    return r;
  endfunction

  // advance the frame tracker by one accepted byte
  task automatic track_byte(input in_item_t it);
    logic [15:0]      w;
    logic [SlotW-1:0] slot;
    frame_status_e    st;
    w = {hi_hold, it.rx_byte};
    if (it.frame_first) begin
      // an early header closes the open frame as short
      if (fr_open) expected_frames.push_back(frame_result(STATUS_SHORT));
      fr_open     = 1'b1;
      hdr_ok      = (it.rx_byte == cmd_cfg);
      csum        = {8'h00, cmd_cfg};
      hi_hold     = 8'h00;
      frame_words = '{default: 16'h0000};
      pos         = FirstIdx;
    end else if (fr_open) begin
      if (pos[0]) begin
        hi_hold = it.rx_byte;
        pos     = pos + 1'b1;
      end else if (pos <= LastDataIdx) begin
        slot              = SlotW'(pos >> 1) - 1'b1;
        frame_words[slot] = w;
        csum              = csum + w;
        pos               = pos + 1'b1;
      end else begin
        // closing checksum word; bad header takes priority
        if (!hdr_ok) st = STATUS_BAD_HEADER;
        else if (w != csum) st = STATUS_BAD_CHECKSUM;
        else st = STATUS_OK;
        expected_frames.push_back(frame_result(st));
        fr_open = 1'b0;
        pos     = '0;
      end
    end
  endtask

  task automatic cmp_field(input string name, input logic [15:0] exp_v,
                           input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_frames.size() == 0) begin
      $error("frame result with none expected: %h", got);
      err_cnt++;
    end else begin
      want = expected_frames.pop_front();
      cmp_field("roll_raw", want.roll_raw, got.roll_raw);
      cmp_field("pitch_raw", want.pitch_raw, got.pitch_raw);
      cmp_field("yaw_raw", want.yaw_raw, got.yaw_raw);
      cmp_field("accel_x_raw", want.accel_x_raw, got.accel_x_raw);
      cmp_field("accel_y_raw", want.accel_y_raw, got.accel_y_raw);
      cmp_field("accel_z_raw", want.accel_z_raw, got.accel_z_raw);
      cmp_field("rate_x_raw", want.rate_x_raw, got.rate_x_raw);
      cmp_field("rate_y_raw", want.rate_y_raw, got.rate_y_raw);
      cmp_field("rate_z_raw", want.rate_z_raw, got.rate_z_raw);
      cmp_field("timer_word", want.timer_word, got.timer_word);
      cmp_field("frame_status", 16'(want.frame_status), 16'(got.frame_status));
    end
  endtask

  // monitor: results, accepted bytes and register writes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_item_o);
      byte_taken = in_valid_i && in_ready_o;
      if (byte_taken) track_byte(in_item_i);
      if (cfg_we_i) cmd_cfg = cfg_wdata_i;
    end else begin
      byte_taken = 1'b0;
    end
  end

  // byte driver: bursts of random length with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || byte_taken) begin
      if (gap_left != 0 || pending_bytes.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_item_i  <= pending_bytes.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // result receiver: rotating stall pattern, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_go && hold_cnt < HoldCycles) begin
      hold_cnt++;
      out_ready_i <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0:       rdy_pat = 16'hFFFF;
          1:       rdy_pat = 16'($urandom);
          2:       rdy_pat = 16'($urandom) | 16'($urandom);
          default: rdy_pat = 16'($urandom) & 16'($urandom);
        endcase
        pat_age = 48;
      end
      pat_age--;
      out_ready_i <= rdy_pat[0];
      rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
    end
  end

  // queue one frame: the first keep bytes go out now, the rest are carried over
  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] cmd,
                            input logic [15:0] words [DataWords],
                            input logic [15:0] sum_flip,
                            input int unsigned nbytes, input int unsigned keep);
    logic [7:0]  fb [FrameBytes];
    logic [15:0] sum;
    in_item_t    it;
    sum   = {8'h00, cmd};
    fb[0] = hdr;
    for (int k = 0; k < DataWords; k++) begin
      fb[2*k+1] = words[k][15:8];
      fb[2*k+2] = words[k][7:0];
      sum       = sum + words[k];
    end
    sum = sum ^ sum_flip;
    fb[FrameBytes-2] = sum[15:8];
    fb[FrameBytes-1] = sum[7:0];
    for (int unsigned i = 0; i < nbytes; i++) begin
      it.rx_byte     = fb[i];
      it.frame_first = (i == 0);
      if (i < keep) pending_bytes.push_back(it);
      else carried_bytes.push_back(it);
    end
    queued_bytes += nbytes;
  endtask

  // random frame: mostly well formed, some with bad header, bad sum, cut short or noise
  task automatic random_frame(input logic [7:0] cmd, input int unsigned keep);
    logic [15:0] w [DataWords];
    logic [7:0]  hdr;
    logic [15:0] flip;
    int unsigned n;
    int unsigned pick;
    in_item_t    stray;
    for (int k = 0; k < DataWords; k++) begin
      case ($urandom_range(0, 9))
        0:       w[k] = 16'h8000;
        1:       w[k] = 16'h7FFF;
        2:       w[k] = 16'hFFFF;
        3:       w[k] = 16'h0000;
        default: w[k] = 16'($urandom);
      endcase
    end
    hdr  = cmd;
    flip = 16'h0000;
    n    = FrameBytes;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      hdr = cmd ^ 8'($urandom_range(1, 255));
      if (pick < 5) flip = 16'($urandom_range(1, 65535));
    end else if (pick < 25) begin
      flip = 16'($urandom_range(1, 65535));
    end else if (pick < 38) begin
      n = $urandom_range(1, FrameBytes - 1);
    end else if (pick < 46) begin
      // stray bytes between frames (absorbed if a short frame is still open)
      repeat ($urandom_range(1, 4)) begin
        stray.rx_byte     = 8'($urandom);
        stray.frame_first = 1'b0;
        pending_bytes.push_back(stray);
      end
    end
    send_frame(hdr, cmd, w, flip, n, keep);
  endtask

  // wait until every queued byte is taken and every result has arrived
  task automatic drain_block();
    while (pending_bytes.size() != 0 || in_valid_i || expected_frames.size() != 0)
      @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
  endtask

  // run timeout
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [7:0]  cmd_plan [5];
    logic [7:0]  phase_cmd;
    logic [15:0] zero_words [DataWords];
    logic [15:0] edge_words [DataWords];
    in_item_t    stray;
    zero_words = '{default: 16'h0000};
    edge_words = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001,
                   16'hFFFE, 16'h5555, 16'hAAAA, 16'h8001, 16'hFFFF};
    cmd_plan   = '{8'($urandom), 8'h00, 8'hFF, 8'($urandom), CmdReset};
    phase_cmd  = CmdReset;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: stray byte, lone header closed early, frame of extreme words
    stray.rx_byte     = 8'hFF;
    stray.frame_first = 1'b0;
    pending_bytes.push_back(stray);
    send_frame(phase_cmd, phase_cmd, zero_words, 16'h0000, 1, 1);
    send_frame(phase_cmd, phase_cmd, edge_words, 16'h0000, FrameBytes, FrameBytes);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 1) hold_go = 1'b1;
      queued_bytes = 0;
      while (queued_bytes < PhaseBytes) random_frame(phase_cmd, FrameBytes);
      // leave a frame open across the register write
      random_frame(phase_cmd, $urandom_range(1, FrameBytes - 1));
      drain_block();

      // command byte write while idle
      cfg_wdata_i <= cmd_plan[ph];
      cfg_we_i    <= 1'b1;
      @(negedge clk_i);
      cfg_we_i    <= 1'b0;
      phase_cmd = cmd_plan[ph];
      while (carried_bytes.size() != 0) pending_bytes.push_back(carried_bytes.pop_front());
    end

    // close whatever frame is open, then finish
    random_frame(phase_cmd, FrameBytes);
    drain_block();
    if (err_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
